[hw/rtl/dpss_pkg.sv]
// Shared types and codes for the drive power state supervisor.
package dpss_pkg;

    // Power drive system states
    typedef enum logic [2:0] {
        ST_NOT_READY = 3'd0,
        ST_SOD       = 3'd1,
        ST_READY     = 3'd2,
        ST_SWON      = 3'd3,
        ST_OPEN      = 3'd4,
        ST_QSA       = 3'd5,
        ST_FRA       = 3'd6,
        ST_FAULT     = 3'd7
    } t_state;

    // Decoded controlword commands
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_SHUTDOWN = 3'd1;
    localparam logic [2:0] CMD_SWITCHON = 3'd2;
    localparam logic [2:0] CMD_ENABLE   = 3'd3;
    localparam logic [2:0] CMD_DISVOLT  = 3'd4;
    localparam logic [2:0] CMD_QSTOP    = 3'd5;

    // Drive action codes
    localparam logic [3:0] AC_NONE     = 4'd0;
    localparam logic [3:0] AC_SHUTDOWN = 4'd1;
    localparam logic [3:0] AC_SWITCHON = 4'd2;
    localparam logic [3:0] AC_ENABLE   = 4'd3;
    localparam logic [3:0] AC_DISOP    = 4'd4;
    localparam logic [3:0] AC_DISVOLT  = 4'd5;
    localparam logic [3:0] AC_QSTOP    = 4'd6;
    localparam logic [3:0] AC_FRESET   = 4'd7;
    localparam logic [3:0] AC_REACT    = 4'd8;

    // Action answers
    localparam logic [1:0] RES_BUSY  = 2'd0;
    localparam logic [1:0] RES_DONE  = 2'd1;
    localparam logic [1:0] RES_ERROR = 2'd2;

    // Takeover priorities
    localparam logic [1:0] PRIO_NONE  = 2'd0;
    localparam logic [1:0] PRIO_QSTOP = 2'd1;
    localparam logic [1:0] PRIO_VOLT  = 2'd2;

    localparam logic [7:0] MASK_RESET = 8'hFF;

    typedef struct packed {
        logic       operation;
        logic [2:0] command;
        logic       fault_reset_bit;
        logic       mode_pending;
        logic [1:0] action_result;
        logic [1:0] reaction_result;
    } t_item;

    typedef struct packed {
        t_state     drive_state;
        logic [3:0] action_called;
        logic       reaction_called;
        logic       cancel_mode;
        logic       owner_busy;
        logic       fault_reset_active;
    } t_result;

    // Supervisor context carried from tick to tick
    typedef struct packed {
        t_state     st;
        logic [2:0] pend_action;
        logic [2:0] pend_target;
        logic       reset_busy;
        logic       reset_bit_prev;
    } t_ctx;

endpackage

[hw/rtl/dpss_in_if.sv]
// Input channel carrying one supervisor tick.
interface dpss_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [2:0] command;
    logic       fault_reset_bit;
    logic       mode_pending;
    logic [1:0] action_result;
    logic [1:0] reaction_result;

    modport source (
        output valid, operation, command, fault_reset_bit, mode_pending,
               action_result, reaction_result,
        input  ready
    );
    modport sink (
        input  valid, operation, command, fault_reset_bit, mode_pending,
               action_result, reaction_result,
        output ready
    );
endinterface

[hw/rtl/dpss_out_if.sv]
// Output channel carrying one supervisor result.
interface dpss_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] drive_state;
    logic [3:0] action_called;
    logic       reaction_called;
    logic       cancel_mode;
    logic       owner_busy;
    logic       fault_reset_active;

    modport source (
        output valid, drive_state, action_called, reaction_called, cancel_mode,
               owner_busy, fault_reset_active,
        input  ready
    );
    modport sink (
        input  valid, drive_state, action_called, reaction_called, cancel_mode,
               owner_busy, fault_reset_active,
        output ready
    );
endinterface

[hw/rtl/dpss_step.sv]
// Combinational next-context and result logic for one supervisor tick.
module dpss_step (
    input  dpss_pkg::t_item   i_item,
    input  dpss_pkg::t_ctx    i_ctx,
    input  logic [7:0]        i_mask,
    output dpss_pkg::t_ctx    o_ctx,
    output dpss_pkg::t_result o_res
);
    import dpss_pkg::*;

    typedef struct packed {
        logic       hit;
        logic [1:0] res;
    } t_call;

    // Call one action: a missing action answers error and is not reported
    function automatic t_call f_call(input logic [3:0] code, input logic [7:0] mask,
                                     input logic [1:0] ares, input logic [1:0] rres);
        t_call      c;
        logic [2:0] idx;
        logic [1:0] raw;
        idx   = 3'(code - 4'd1);
        raw   = (code == AC_REACT) ? rres : ares;
        c.hit = mask[idx];
        if (!c.hit) begin
            c.res = RES_ERROR;
        end else if (raw == RES_BUSY || raw == RES_DONE) begin
            c.res = raw;
        end else begin
            c.res = RES_ERROR;
        end
        return c;
    endfunction

    t_state     st;
    t_state     act_tgt;
    t_state     tk_tgt;
    logic [2:0] pa;
    logic [2:0] pt;
    logic       rip;
    logic       prev;
    logic [3:0] called;
    logic       react2;
    logic       cancel;
    logic       edge_det;
    logic       tk;
    logic [3:0] tk_code;
    logic [1:0] want;
    logic [1:0] have;
    logic       run_act;
    logic [3:0] act_code;
    logic       run_react;
    logic       run_freset;
    t_call      c_act;
    t_call      c_fr;
    t_call      c_re;

    always_comb begin
        st         = i_ctx.st;
        pa         = i_ctx.pend_action;
        pt         = i_ctx.pend_target;
        rip        = i_ctx.reset_busy;
        prev       = i_ctx.reset_bit_prev;
        called     = AC_NONE;
        react2     = 1'b0;
        cancel     = 1'b0;
        run_act    = 1'b0;
        act_code   = AC_NONE;
        act_tgt    = ST_NOT_READY;
        run_react  = 1'b0;
        run_freset = 1'b0;
        edge_det   = i_item.fault_reset_bit && !i_ctx.reset_bit_prev;
        tk_code    = AC_NONE;
        tk_tgt     = ST_NOT_READY;
        want       = PRIO_NONE;
        c_act      = '0;
        c_fr       = '0;
        c_re       = '0;

        // Pick a safety takeover candidate
        if (i_item.command == CMD_DISVOLT) begin
            tk_code = AC_DISVOLT;
            tk_tgt  = ST_SOD;
            want    = PRIO_VOLT;
        end else if (i_item.command == CMD_QSTOP &&
                     (i_ctx.st == ST_OPEN || i_ctx.pend_target == ST_OPEN)) begin
            tk_code = AC_QSTOP;
            tk_tgt  = ST_QSA;
            want    = PRIO_QSTOP;
        end
        have = (i_ctx.pend_target == ST_SOD) ? PRIO_VOLT :
               (i_ctx.pend_target == ST_QSA) ? PRIO_QSTOP : PRIO_NONE;
        tk   = (want != PRIO_NONE) &&
               (i_ctx.pend_action != 3'd0 || i_item.mode_pending) && (have < want);

        // Decide what this tick launches
        if (i_item.operation) begin
            if (!(i_ctx.st == ST_FAULT && !i_ctx.reset_busy &&
                  i_ctx.pend_action == 3'd0 && !i_item.mode_pending)) begin
                cancel    = i_item.mode_pending;
                pa        = 3'd0;
                pt        = 3'd0;
                rip       = 1'b0;
                st        = ST_FRA;
                run_react = 1'b1;
            end
        end else begin
            prev = i_item.fault_reset_bit;
            if (tk) begin
                cancel   = i_item.mode_pending;
                rip      = 1'b0;
                run_act  = 1'b1;
                act_code = tk_code;
                act_tgt  = tk_tgt;
            end else if (i_item.mode_pending) begin
                run_act = 1'b0;
            end else if (i_ctx.pend_action != 3'd0) begin
                run_act  = 1'b1;
                act_code = {1'b0, i_ctx.pend_action};
                act_tgt  = t_state'(i_ctx.pend_target);
            end else begin
                case (i_ctx.st)
                    ST_NOT_READY: begin
                        st = ST_SOD;
                    end
                    ST_SOD: begin
                        if (i_item.command == CMD_SHUTDOWN) begin
                            run_act = 1'b1; act_code = AC_SHUTDOWN; act_tgt = ST_READY;
                        end
                    end
                    ST_READY: begin
                        if (i_item.command == CMD_DISVOLT) begin
                            run_act = 1'b1; act_code = AC_DISVOLT; act_tgt = ST_SOD;
                        end else if (i_item.command == CMD_SWITCHON) begin
                            run_act = 1'b1; act_code = AC_SWITCHON; act_tgt = ST_SWON;
                        end
                    end
                    ST_SWON: begin
                        if (i_item.command == CMD_DISVOLT) begin
                            run_act = 1'b1; act_code = AC_DISVOLT; act_tgt = ST_SOD;
                        end else if (i_item.command == CMD_SHUTDOWN) begin
                            run_act = 1'b1; act_code = AC_SHUTDOWN; act_tgt = ST_READY;
                        end else if (i_item.command == CMD_ENABLE) begin
                            run_act = 1'b1; act_code = AC_ENABLE; act_tgt = ST_OPEN;
                        end
                    end
                    ST_OPEN: begin
                        if (i_item.command == CMD_QSTOP) begin
                            run_act = 1'b1; act_code = AC_QSTOP; act_tgt = ST_QSA;
                        end else if (i_item.command == CMD_DISVOLT) begin
                            run_act = 1'b1; act_code = AC_DISVOLT; act_tgt = ST_SOD;
                        end else if (i_item.command == CMD_SHUTDOWN) begin
                            run_act = 1'b1; act_code = AC_SHUTDOWN; act_tgt = ST_READY;
                        end else if (i_item.command == CMD_SWITCHON) begin
                            run_act = 1'b1; act_code = AC_DISOP; act_tgt = ST_SWON;
                        end
                    end
                    ST_QSA: begin
                        if (i_item.command == CMD_DISVOLT) begin
                            run_act = 1'b1; act_code = AC_DISVOLT; act_tgt = ST_SOD;
                        end
                    end
                    ST_FRA: begin
                        run_react = 1'b1;
                    end
                    default: begin
                        if (i_ctx.reset_busy || edge_det) begin
                            rip        = 1'b1;
                            run_freset = 1'b1;
                        end
                    end
                endcase
            end
        end

        // Run the drive action, latch it while busy
        if (run_act) begin
            c_act = f_call(act_code, i_mask, i_item.action_result, i_item.reaction_result);
            if (c_act.hit) begin
                called = act_code;
            end
            if (c_act.res == RES_BUSY) begin
                pa = act_code[2:0];
                pt = act_tgt;
            end else begin
                pa = 3'd0;
                pt = 3'd0;
                if (c_act.res == RES_DONE) begin
                    st = act_tgt;
                end else begin
                    rip = 1'b0;
                    st  = ST_FRA;
                end
            end
        end

        // A takeover that lands in fault reaction also runs the reaction
        if (tk && !i_item.operation && st == ST_FRA) begin
            run_react = 1'b1;
        end

        // Run the fault reset
        if (run_freset) begin
            c_fr = f_call(AC_FRESET, i_mask, i_item.action_result, i_item.reaction_result);
            if (c_fr.hit) begin
                called = AC_FRESET;
            end
            if (c_fr.res != RES_BUSY) begin
                rip = 1'b0;
                st  = (c_fr.res == RES_DONE) ? ST_SOD : ST_FRA;
            end
        end

        // Run the fault reaction
        if (run_react) begin
            c_re = f_call(AC_REACT, i_mask, i_item.action_result, i_item.reaction_result);
            if (c_re.hit) begin
                if (called == AC_NONE) begin
                    called = AC_REACT;
                end else begin
                    react2 = 1'b1;
                end
            end
            if (c_re.res != RES_BUSY) begin
                st = ST_FAULT;
            end
        end
    end

    // Pack next context and result
    always_comb begin
        o_ctx.st                 = st;
        o_ctx.pend_action        = pa;
        o_ctx.pend_target        = pt;
        o_ctx.reset_busy         = rip;
        o_ctx.reset_bit_prev     = prev;
        o_res.drive_state        = st;
        o_res.action_called      = called;
        o_res.reaction_called    = react2;
        o_res.cancel_mode        = cancel;
        o_res.owner_busy         = (pa != 3'd0);
        o_res.fault_reset_active = rip;
    end

endmodule

[hw/rtl/drive_power_state_supervisor.sv]
// CiA 402 drive power state supervisor: input register, step logic, result register.
// A tick waits in the input register until the result register can take its result.
// Throughput: one tick per cycle while the sink takes results; the context advances once per tick.
// The next tick is taken while a finished result waits in the result register.
// Reset (synchronous, active low): state not ready to switch on, no action latched,
// no fault reset in progress, reset bit history low, action mask all ones, channels empty.
module drive_power_state_supervisor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    dpss_in_if.sink    i_in,
    dpss_out_if.source o_out
);
    import dpss_pkg::*;

    logic      r_item_vld;
    t_item     r_item;
    logic      r_res_vld;
    t_result   r_res;
    t_ctx      r_ctx;
    logic [7:0] r_mask;
    t_ctx      n_ctx;
    t_result   n_res;
    logic      adv;
    logic      in_fire;

    assign adv        = r_item_vld && (!r_res_vld || o_out.ready);
    assign i_in.ready = !r_item_vld || adv;
    assign in_fire    = i_in.valid && i_in.ready;

    // Hold the action mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    // Capture the input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (in_fire) begin
            r_item_vld <= 1'b1;
        end else if (adv) begin
            r_item_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.operation       <= i_in.operation;
            r_item.command         <= i_in.command;
            r_item.fault_reset_bit <= i_in.fault_reset_bit;
            r_item.mode_pending    <= i_in.mode_pending;
            r_item.action_result   <= i_in.action_result;
            r_item.reaction_result <= i_in.reaction_result;
        end
    end

    dpss_step u_step (
        .i_item (r_item),
        .i_ctx  (r_ctx),
        .i_mask (r_mask),
        .o_ctx  (n_ctx),
        .o_res  (n_res)
    );

    // Advance the supervisor context once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.st             <= ST_NOT_READY;
            r_ctx.pend_action    <= 3'd0;
            r_ctx.pend_target    <= 3'd0;
            r_ctx.reset_busy     <= 1'b0;
            r_ctx.reset_bit_prev <= 1'b0;
        end else if (adv) begin
            r_ctx <= n_ctx;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (adv) begin
            r_res_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid              = r_res_vld;
    assign o_out.drive_state        = r_res.drive_state;
    assign o_out.action_called      = r_res.action_called;
    assign o_out.reaction_called    = r_res.reaction_called;
    assign o_out.cancel_mode        = r_res.cancel_mode;
    assign o_out.owner_busy         = r_res.owner_busy;
    assign o_out.fault_reset_active = r_res.fault_reset_active;

endmodule
